FILE: src/kufe_pkg.sv
// ----------------------------------------------------------------------------
// kufe_pkg
// Shared widths, constants and controller/datapath interface types for the
// union-find edge stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package kufe_pkg;

  localparam int NODE_W = 7;
  localparam int COST_W = 16;
  localparam int SUM_W  = 24;
  localparam int RANK_W = 3;
  localparam int LIM_W  = 7;

  localparam logic [RANK_W-1:0] RANK_MAX  = 3'd7;
  localparam logic [SUM_W-1:0]  SUM_MAX   = 24'hFFFFFF;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 7'd127;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic launch;   // check eligibility, start read of from_node
    logic find_a;   // one parent hop for from_node
    logic find_b;   // one parent hop for to_node
    logic link;     // union of the two roots
    logic rank_up;  // bump rank of the surviving root
    logic emit;     // load the output register
  } kufe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eligible;
    logic at_root;
    logic roots_differ;
    logic ranks_equal;
    logic out_free;
  } kufe_sts_t;

endpackage

`default_nettype wire

FILE: src/kufe_ctrl.sv
// ----------------------------------------------------------------------------
// kufe_ctrl
// Sequencer for one edge: accept, two root walks, union, result.
// ----------------------------------------------------------------------------
`default_nettype none

module kufe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  kufe_pkg::kufe_sts_t     sts,
  output kufe_pkg::kufe_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_FIND_A = 3'd2;
  localparam logic [2:0] S_FIND_B = 3'd3;
  localparam logic [2:0] S_LINK   = 3'd4;
  localparam logic [2:0] S_RANK   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_LAUNCH;
      end
      S_LAUNCH: begin
        cmd.launch = 1'b1;
        state_nxt  = sts.eligible ? S_FIND_A : S_EMIT;
      end
      S_FIND_A: begin
        cmd.find_a = 1'b1;
        if (sts.at_root) state_nxt = S_FIND_B;
      end
      S_FIND_B: begin
        cmd.find_b = 1'b1;
        if (sts.at_root) state_nxt = S_LINK;
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = (sts.roots_differ && sts.ranks_equal) ? S_RANK : S_EMIT;
      end
      S_RANK: begin
        cmd.rank_up = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LAUNCH))
    else $error("accepted item not launched");

endmodule

`default_nettype wire

FILE: src/kufe_dpath.sv
// ----------------------------------------------------------------------------
// kufe_dpath
// Parent/rank store, root walk, union by rank, count and saturating sum,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kufe_dpath #(
  parameter int NODES = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  kufe_pkg::kufe_cmd_t                cmd,
  output kufe_pkg::kufe_sts_t                sts,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kufe_pkg::LIM_W-1:0]    cfg_wr_data,
  input  wire logic [kufe_pkg::NODE_W-1:0]   in_from_node,
  input  wire logic [kufe_pkg::NODE_W-1:0]   in_to_node,
  input  wire logic [kufe_pkg::COST_W-1:0]   in_edge_cost,
  input  wire logic                          in_first_edge,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_accepted,
  output logic [kufe_pkg::SUM_W-1:0]         out_total_cost,
  output logic                               out_tree_done
);

  localparam int IDX_W = $clog2(NODES);
  localparam int ENT_W = kufe_pkg::RANK_W + IDX_W;

  // entry layout: {rank, parent}
  logic [ENT_W-1:0] mem [NODES];
  logic [NODES-1:0] valid_r;

  logic [kufe_pkg::NODE_W-1:0] from_r;
  logic [kufe_pkg::NODE_W-1:0] to_r;
  logic [kufe_pkg::COST_W-1:0] cost_r;
  logic [kufe_pkg::LIM_W-1:0]  limit_r;
  logic [kufe_pkg::LIM_W-1:0]  count_r;
  logic [kufe_pkg::SUM_W-1:0]  sum_r;
  logic                        acc_r;
  logic [IDX_W-1:0]            cur_r;
  logic [IDX_W-1:0]            ra_r;
  logic [IDX_W-1:0]            rb_r;
  logic [kufe_pkg::RANK_W-1:0] rka_r;
  logic [kufe_pkg::RANK_W-1:0] rkb_r;
  logic [ENT_W-1:0]            rd_ent_r;
  logic                        rd_vld_r;

  logic                        out_valid_r;
  logic                        out_acc_r;
  logic [kufe_pkg::SUM_W-1:0]  out_sum_r;
  logic                        out_done_r;

  logic [IDX_W-1:0]            cur_parent;
  logic [kufe_pkg::RANK_W-1:0] cur_rank;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [ENT_W-1:0]            wr_data;
  logic [kufe_pkg::RANK_W-1:0] rkb_inc;
  logic [kufe_pkg::SUM_W:0]    sum_wide;
  logic                        joined;

  // an entry never written this pass reads as its own root with rank zero
  assign cur_parent = rd_vld_r ? rd_ent_r[IDX_W-1:0] : cur_r;
  assign cur_rank   = rd_vld_r ? rd_ent_r[ENT_W-1:IDX_W] : '0;

  assign sts.eligible     = (count_r < limit_r) && (32'(from_r) < 32'(NODES))
                            && (32'(to_r) < 32'(NODES));
  assign sts.at_root      = (cur_parent == cur_r);
  assign sts.roots_differ = (ra_r != rb_r);
  assign sts.ranks_equal  = (rka_r == rkb_r);
  assign sts.out_free     = !out_valid_r || out_ready;

  assign joined   = cmd.link && (ra_r != rb_r);
  assign rkb_inc  = (rkb_r == kufe_pkg::RANK_MAX) ? rkb_r : rkb_r + 1'b1;
  assign sum_wide = {1'b0, sum_r} + {{(kufe_pkg::SUM_W + 1 - kufe_pkg::COST_W){1'b0}}, cost_r};

  always_comb begin
    if (cmd.launch) begin
      rd_addr = IDX_W'(from_r);
    end else if (cmd.find_a && sts.at_root) begin
      rd_addr = IDX_W'(to_r);
    end else begin
      rd_addr = cur_parent;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rb_r;
    wr_data = {rkb_inc, rb_r};
    if (cmd.rank_up) begin
      wr_en = 1'b1;
    end else if (joined) begin
      wr_en = 1'b1;
      if (rka_r > rkb_r) begin
        wr_addr = rb_r;
        wr_data = {rkb_r, ra_r};
      end else begin
        wr_addr = ra_r;
        wr_data = {rka_r, rb_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_ent_r <= mem[rd_addr];
    rd_vld_r <= valid_r[rd_addr];
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      from_r <= in_from_node;
      to_r   <= in_to_node;
      cost_r <= in_edge_cost;
    end
    if (cmd.launch || cmd.find_a || cmd.find_b) cur_r <= rd_addr;
    if (cmd.find_a && sts.at_root) begin
      ra_r  <= cur_r;
      rka_r <= cur_rank;
    end
    if (cmd.find_b && sts.at_root) begin
      rb_r  <= cur_r;
      rkb_r <= cur_rank;
    end
    if (cmd.emit) begin
      out_acc_r  <= acc_r;
      out_sum_r  <= sum_r;
      out_done_r <= (count_r >= limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      limit_r     <= kufe_pkg::LIMIT_RST;
      count_r     <= '0;
      sum_r       <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.load) begin
        acc_r <= 1'b0;
        if (in_first_edge) begin
          valid_r <= '0;
          count_r <= '0;
          sum_r   <= '0;
        end
      end
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (joined) begin
        acc_r   <= 1'b1;
        count_r <= count_r + 1'b1;
        sum_r   <= sum_wide[kufe_pkg::SUM_W] ? kufe_pkg::SUM_MAX
                                             : sum_wide[kufe_pkg::SUM_W-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_total_cost = out_sum_r;
  assign out_tree_done  = out_done_r;

  a_link_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    joined |-> (count_r < limit_r))
    else $error("union past the edge limit");

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_first_edge) |=> (count_r == '0 && sum_r == '0 && valid_r == '0))
    else $error("new pass did not clear state");

  a_rank_after_tie: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank_up |-> ($past(joined) && sts.ranks_equal))
    else $error("rank bump without a tied union");

endmodule

`default_nettype wire

FILE: src/kruskal_union_find_edge_stream.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_stream
// Minimum spanning tree accumulator over a stream of cost-sorted edges.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one edge per item (valid/ready). in_first_edge starts a new pass,
//           clearing the forest, ranks, edge count and cost sum first.
//   out_* : one result per edge (valid/ready): accepted flag, saturating
//           running cost, and tree_done once node_limit edges are taken.
//   cfg_* : cfg_wr_en writes node_limit from cfg_wr_data; write only while
//           the block is idle.
// Timing: after an item is accepted, LAUNCH reads from_node's entry; FIND_A
//   and FIND_B then walk the parent links from each endpoint to its root,
//   one store read per hop; LINK joins differing roots, RANK follows on a
//   rank tie, and EMIT loads the output register. Union by rank keeps hops
//   near log2(NODES). Ineligible edges go from LAUNCH straight to EMIT.
//   One item is in flight at a time.
// Reset: node_limit returns to 127, the forest is empty (every node its own
//   root), count and sum are zero. No clearing sweep is needed.
// Stall: a finished result waits in the output register; the block holds
//   the next result until out_ready takes the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_stream #(
  parameter int NODES = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kufe_pkg::LIM_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kufe_pkg::NODE_W-1:0]   in_from_node,
  input  wire logic [kufe_pkg::NODE_W-1:0]   in_to_node,
  input  wire logic [kufe_pkg::COST_W-1:0]   in_edge_cost,
  input  wire logic                          in_first_edge,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_accepted,
  output logic [kufe_pkg::SUM_W-1:0]         out_total_cost,
  output logic                               out_tree_done
);

  kufe_pkg::kufe_cmd_t cmd;
  kufe_pkg::kufe_sts_t sts;

  kufe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kufe_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_edge_cost   (in_edge_cost),
    .in_first_edge  (in_first_edge),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_total_cost (out_total_cost),
    .out_tree_done  (out_tree_done)
  );

endmodule

`default_nettype wire
